// ===== rtl/core/sprc_pkg.sv =====
// Package for the subpacket reassembly checker.
// Holds the channel payload types, configuration types and status codes.
// No dependencies.
`timescale 1ns / 1ps

package sprc_pkg;

    // Saturation limit of the byte counter and the byte offset
    localparam logic [15:0] MAX_BYTES = 16'hFFFF;

    // Configuration reset values
    localparam logic [7:0]  SCAN_CODE_RST      = 8'd2;
    localparam logic [15:0] MIN_SCAN_BYTES_RST = 16'd200;

    // Configuration register indexes
    typedef enum logic {
        CFG_SCAN_CODE      = 1'b0,
        CFG_MIN_SCAN_BYTES = 1'b1
    } cfg_index_t;

    // Item kinds carried in func
    typedef enum logic {
        FUNC_HEADER = 1'b0,
        FUNC_BYTE   = 1'b1
    } func_t;

    // Header status codes
    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_BAD_START  = 3'd1,
        ST_CODE_MISM  = 3'd2,
        ST_SEQ_GAP    = 3'd3,
        ST_NOT_HEADER = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  scan_code;
        logic [15:0] min_scan_bytes;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [7:0] long_id;
        logic [7:0] data_kind;
        logic [7:0] sub_number;
        logic [7:0] sub_total;
        logic [7:0] payload_len;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  header_status;
        logic        byte_valid;
        logic [7:0]  byte_out;
        logic [15:0] byte_offset;
        logic        packet_done;
        logic        scan_ready;
        logic [15:0] total_bytes;
    } out_item_t;

endpackage

// ===== rtl/core/sprc_engine.sv =====
// Reassembly state and per-item checks of the subpacket reassembly checker.
// Depends on sprc_pkg.
`timescale 1ns / 1ps

module sprc_engine
    import sprc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_accept,
    input  in_item_t  in_data,
    input  cfg_t      cfg,
    output out_item_t res
);

    logic        record_valid_reg, record_valid_next;
    logic [7:0]  stored_id_reg, stored_id_next;
    logic [7:0]  stored_code_reg, stored_code_next;
    logic [7:0]  last_number_reg, last_number_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic        sub_accepted_reg, sub_accepted_next;
    logic        sub_final_reg, sub_final_next;

    status_t     status;
    logic        new_id;
    logic        seq_ok;
    logic        hdr_final;

    // Header decode
    assign new_id    = !record_valid_reg || (in_data.long_id != stored_id_reg);
    assign seq_ok    = (in_data.sub_number == 8'd0) ||
                       ({1'b0, in_data.sub_number} == ({1'b0, last_number_reg} + 9'd1));
    assign hdr_final = (in_data.sub_total != 8'd0) &&
                       (in_data.sub_number == (in_data.sub_total - 8'd1));

    // Compute the result and the next state for the item on the input
    always_comb begin
        record_valid_next = record_valid_reg;
        stored_id_next    = stored_id_reg;
        stored_code_next  = stored_code_reg;
        last_number_next  = last_number_reg;
        byte_count_next   = byte_count_reg;
        bytes_left_next   = bytes_left_reg;
        sub_accepted_next = sub_accepted_reg;
        sub_final_next    = sub_final_reg;
        status            = ST_NOT_HEADER;
        res               = '0;

        if (in_data.func == FUNC_HEADER) begin
            sub_accepted_next = 1'b0;
            sub_final_next    = 1'b0;
            bytes_left_next   = 8'd0;
            if (new_id) begin
                if (in_data.sub_number != 8'd0) begin
                    record_valid_next = 1'b0;
                    byte_count_next   = 16'd0;
                    status            = ST_BAD_START;
                end else begin
                    record_valid_next = 1'b1;
                    stored_id_next    = in_data.long_id;
                    stored_code_next  = in_data.data_kind;
                    byte_count_next   = 16'd0;
                    status            = ST_ACCEPTED;
                end
            end else if (in_data.data_kind != stored_code_reg) begin
                status = ST_CODE_MISM;
            end else if (!seq_ok) begin
                status = ST_SEQ_GAP;
            end else begin
                status = ST_ACCEPTED;
            end

            // Open the subpacket; an empty one completes at its header
            if (status == ST_ACCEPTED) begin
                last_number_next = in_data.sub_number;
                bytes_left_next  = in_data.payload_len;
                if (in_data.payload_len == 8'd0) begin
                    res.packet_done = hdr_final;
                    res.scan_ready  = hdr_final &&
                                      (stored_code_next == cfg.scan_code) &&
                                      (byte_count_next > cfg.min_scan_bytes);
                end else begin
                    sub_accepted_next = 1'b1;
                    sub_final_next    = hdr_final;
                end
            end
        end else if (sub_accepted_reg && (bytes_left_reg != 8'd0)) begin
            // Pass the byte out and advance the saturating count
            res.byte_valid  = 1'b1;
            res.byte_out    = in_data.data_byte;
            res.byte_offset = byte_count_reg;
            if (byte_count_reg < MAX_BYTES) begin
                byte_count_next = byte_count_reg + 16'd1;
            end
            bytes_left_next = bytes_left_reg - 8'd1;
            if (bytes_left_next == 8'd0) begin
                res.packet_done   = sub_final_reg;
                res.scan_ready    = sub_final_reg &&
                                    (stored_code_reg == cfg.scan_code) &&
                                    (byte_count_next > cfg.min_scan_bytes);
                sub_accepted_next = 1'b0;
                sub_final_next    = 1'b0;
            end
        end

        res.header_status = status;
        res.total_bytes   = byte_count_next;
    end

    // Update the record on every transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_valid_reg <= 1'b0;
            stored_id_reg    <= 8'd0;
            stored_code_reg  <= 8'd0;
            last_number_reg  <= 8'd0;
            byte_count_reg   <= 16'd0;
            bytes_left_reg   <= 8'd0;
            sub_accepted_reg <= 1'b0;
            sub_final_reg    <= 1'b0;
        end else if (in_accept) begin
            record_valid_reg <= record_valid_next;
            stored_id_reg    <= stored_id_next;
            stored_code_reg  <= stored_code_next;
            last_number_reg  <= last_number_next;
            byte_count_reg   <= byte_count_next;
            bytes_left_reg   <= bytes_left_next;
            sub_accepted_reg <= sub_accepted_next;
            sub_final_reg    <= sub_final_next;
        end
    end

    // A scan flag only comes with a completed packet
    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && res.scan_ready |-> res.packet_done)
        else $error("scan_ready without packet_done");

    // An accepted byte never carries a header status
    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && res.byte_valid |-> res.header_status == ST_NOT_HEADER)
        else $error("byte result with header status");

    // A final subpacket is only tracked while a subpacket is open
    a_final_open: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_final_reg |-> sub_accepted_reg && (bytes_left_reg != 8'd0))
        else $error("final flag without open subpacket");

    // A bad start drops the record and clears the count
    a_bad_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && res.header_status == ST_BAD_START
        |=> !record_valid_reg && (byte_count_reg == 16'd0))
        else $error("bad start left a live record");

endmodule

// ===== rtl/core/sprc_out_buf.sv =====
// Two-entry result buffer that decouples the input from the result channel.
// Depends on sprc_pkg.
`timescale 1ns / 1ps

module sprc_out_buf
    import sprc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_data,
    output logic      has_room,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    out_item_t   slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign has_room = (count_reg != 2'd2);
    assign m_valid  = (count_reg != 2'd0);
    assign m_data   = slot_reg[rd_ptr_reg];
    assign pop      = m_valid && m_ready;

    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // Store results; payload slots need no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> has_room)
        else $error("push into full result buffer");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("result buffer pointers out of step");

endmodule

// ===== rtl/core/subpacket_reassembly_checker.sv =====
// Top level of the subpacket reassembly checker.
// Depends on sprc_pkg, sprc_engine and sprc_out_buf.
//
// Usage:
//   Input channel s_valid / s_ready / s_data carries header and byte items.
//   Result channel m_valid / m_ready / m_data returns exactly one result
//   per input transfer, in order.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (scan_code, min_scan_bytes) at the clock edge; write only while idle.
//   Results are registered in the result buffer. Throughput: one item per
//   cycle while s_ready is high; all checks are a few compares and one
//   16-bit increment between the record registers and the result buffer.
//   Stall: a two-entry result buffer holds results while m_ready is low;
//   s_ready drops once both entries are full and returns as soon as one
//   result is taken, so s_ready never depends on m_ready in the same cycle.
//   Reset (aresetn low, synchronous): the record is cleared, the result
//   buffer is emptied and the registers return to scan_code 2 and
//   min_scan_bytes 200.
`timescale 1ns / 1ps

module subpacket_reassembly_checker
    import sprc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    cfg_t      cfg_reg;
    out_item_t res;
    logic      in_accept;

    assign in_accept = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_code      <= SCAN_CODE_RST;
            cfg_reg.min_scan_bytes <= MIN_SCAN_BYTES_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SCAN_CODE:      cfg_reg.scan_code      <= cfg_wdata[7:0];
                CFG_MIN_SCAN_BYTES: cfg_reg.min_scan_bytes <= cfg_wdata;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    sprc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .res       (res)
    );

    sprc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data (res),
        .has_room  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== sim/tb_subpacket_reassembly_checker.sv =====
// Self-checking testbench for subpacket_reassembly_checker.
// Drives headers and payload bytes, predicts every result in-line and compares.
// Depends on sprc_pkg and the subpacket_reassembly_checker RTL.
`timescale 1ns / 1ps

module tb_subpacket_reassembly_checker;
    import sprc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 40;
    localparam int IN_W        = $bits(in_item_t);

    // Receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_RUNS   = 2;

    // Ways to break a subpacket in the random traffic
    typedef enum int {
        FLT_NONE, FLT_CODE, FLT_SKIP, FLT_RESTART, FLT_SHORT, FLT_EXTRA, FLT_NOISE
    } fault_t;

    typedef struct {
        in_item_t  item;
        bit        has_exp;
        out_item_t exp;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // Expectation typed in by a directed row, traveling with the transfer
    logic        typed_has = 1'b0;
    out_item_t   typed_exp = '0;

    // Predictor copy of the record and registers
    logic        rec_valid    = 1'b0;
    logic [7:0]  rec_id       = '0;
    logic [7:0]  rec_code     = '0;
    logic [7:0]  rec_last     = '0;
    logic [15:0] gathered     = '0;
    logic [7:0]  remaining    = '0;
    logic        sub_open     = 1'b0;
    logic        sub_is_final = 1'b0;
    logic [7:0]  cfg_scan     = SCAN_CODE_RST;
    logic [15:0] cfg_min      = MIN_SCAN_BYTES_RST;

    out_item_t   results_due[$];
    dir_row_t    dir_rows[$];

    int errors      = 0;
    int cycle_count = 0;
    int n_items     = 0;
    int n_checked   = 0;
    int n_accepted  = 0;
    int n_rejected  = 0;
    int n_done      = 0;
    int n_scan      = 0;
    int n_settings  = 0;
    int stall_mode  = STALL_RUNS;
    int stall_run   = 0;
    int gap_max     = 3;
    int burst_left  = 0;

    subpacket_reassembly_checker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Close the open subpacket once its last byte is in
    function automatic void close_subpacket(inout out_item_t r);
        if (sub_open && remaining == 8'd0) begin
            if (sub_is_final) begin
                r.packet_done = 1'b1;
                r.scan_ready  = (rec_code == cfg_scan) && (gathered > cfg_min);
            end
            sub_open     = 1'b0;
            sub_is_final = 1'b0;
        end
    endfunction

    // Advance the record by one transfer and return the result it causes
    function automatic out_item_t predict_reassembly(input in_item_t it);
        out_item_t r;
        status_t   st;
        r  = '0;
        st = ST_NOT_HEADER;
        if (it.func == FUNC_HEADER) begin
            sub_open     = 1'b0;
            sub_is_final = 1'b0;
            remaining    = 8'd0;
            if (!rec_valid || it.long_id != rec_id) begin
                if (it.sub_number != 8'd0) begin
                    rec_valid = 1'b0;
                    gathered  = 16'd0;
                    st        = ST_BAD_START;
                end else begin
                    rec_valid = 1'b1;
                    rec_id    = it.long_id;
                    rec_code  = it.data_kind;
                    rec_last  = 8'd0;
                    gathered  = 16'd0;
                    st        = ST_ACCEPTED;
                end
            end else if (it.data_kind != rec_code) begin
                st = ST_CODE_MISM;
            end else if (it.sub_number != 8'd0 &&
                         {1'b0, it.sub_number} != {1'b0, rec_last} + 9'd1) begin
                st = ST_SEQ_GAP;
            end else begin
                st = ST_ACCEPTED;
            end
            if (st == ST_ACCEPTED) begin
                sub_open     = 1'b1;
                sub_is_final = (it.sub_total != 8'd0) &&
                               (it.sub_number == it.sub_total - 8'd1);
                rec_last     = it.sub_number;
                remaining    = it.payload_len;
                close_subpacket(r);
            end
        end else if (sub_open && remaining != 8'd0) begin
            r.byte_valid  = 1'b1;
            r.byte_out    = it.data_byte;
            r.byte_offset = gathered;
            if (gathered != MAX_BYTES)
                gathered = gathered + 16'd1;
            remaining = remaining - 8'd1;
            close_subpacket(r);
        end
        r.header_status = st;
        r.total_bytes   = gathered;
        return r;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endfunction

    // Predict on every input transfer, check on every result transfer
    always @(posedge aclk) begin : scoreboard
        out_item_t predicted;
        out_item_t want;
        if (aresetn && s_valid && s_ready) begin
            predicted = predict_reassembly(s_data);
            if (predicted.header_status == ST_ACCEPTED)
                n_accepted++;
            else if (predicted.header_status != ST_NOT_HEADER)
                n_rejected++;
            n_done += int'(predicted.packet_done);
            n_scan += int'(predicted.scan_ready);
            results_due = {results_due, (typed_has ? typed_exp : predicted)};
        end
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with none expected, actual %h", $time, m_data);
            end else begin
                want = results_due.pop_front();
                n_checked++;
                check_field("header_status", 32'(want.header_status),
                            32'(m_data.header_status));
                check_field("byte_valid", 32'(want.byte_valid), 32'(m_data.byte_valid));
                check_field("byte_out", 32'(want.byte_out), 32'(m_data.byte_out));
                check_field("byte_offset", 32'(want.byte_offset), 32'(m_data.byte_offset));
                check_field("packet_done", 32'(want.packet_done), 32'(m_data.packet_done));
                check_field("scan_ready", 32'(want.scan_ready), 32'(m_data.scan_ready));
                check_field("total_bytes", 32'(want.total_bytes), 32'(m_data.total_bytes));
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        if (stall_mode == STALL_NONE) begin
            m_ready <= 1'b1;
        end else if (stall_mode == STALL_RANDOM) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else if (stall_run == 0) begin
            m_ready   <= ~m_ready;
            stall_run <= $urandom_range(1, 9);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("** subpacket_reassembly_checker: FAILED **");
            $finish;
        end
    end

    function automatic in_item_t mk_header(input logic [7:0] id, input logic [7:0] code,
                                           input logic [7:0] num, input logic [7:0] total,
                                           input logic [7:0] len);
        in_item_t it;
        it             = '0;
        it.func        = FUNC_HEADER;
        it.long_id     = id;
        it.data_kind   = code;
        it.sub_number  = num;
        it.sub_total   = total;
        it.payload_len = len;
        it.data_byte   = 8'($urandom);
        return it;
    endfunction

    // Header fields of a byte item are junk; the block must ignore them
    function automatic in_item_t mk_byte(input logic [7:0] value);
        in_item_t it;
        it           = in_item_t'(IN_W'({$urandom, $urandom}));
        it.func      = FUNC_BYTE;
        it.data_byte = value;
        return it;
    endfunction

    function automatic out_item_t mk_result(input status_t st, input logic done,
                                            input logic [15:0] total);
        out_item_t r;
        r               = '0;
        r.header_status = st;
        r.packet_done   = done;
        r.total_bytes   = total;
        return r;
    endfunction

    function automatic void add_row(input in_item_t it, input bit has_exp = 1'b0,
                                    input out_item_t exp = '0);
        dir_row_t row;
        row.item    = it;
        row.has_exp = has_exp;
        row.exp     = exp;
        dir_rows    = {dir_rows, row};
    endfunction

    // Present one item, hold it until the transfer, then maybe idle
    task automatic send_item(input in_item_t it, input bit has_exp = 1'b0,
                             input out_item_t exp = '0);
        s_data    <= it;
        s_valid   <= 1'b1;
        typed_has <= has_exp;
        typed_exp <= exp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        n_items++;
        if (gap_max != 0 && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end else if (burst_left != 0) begin
            burst_left--;
        end
    endtask

    // Hold off the sender until every result is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] scan, input logic [15:0] min_bytes);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCAN_CODE;
        cfg_wdata <= {8'd0, scan};
        @(posedge aclk);
        cfg_index <= CFG_MIN_SCAN_BYTES;
        cfg_wdata <= min_bytes;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        cfg_scan = scan;
        cfg_min  = min_bytes;
        n_settings++;
    endtask

    // One long packet with random content, some subpackets broken on purpose
    task automatic send_long_packet();
        logic [7:0] id;
        logic [7:0] code;
        logic [7:0] hcode;
        logic [7:0] total;
        logic [7:0] num;
        logic [7:0] len;
        int         nsub;
        int         nbytes;
        int         pick;
        fault_t     fault;
        id    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        code  = ($urandom_range(0, 2) == 0) ? cfg_scan : 8'($urandom);
        total = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
        nsub  = (total >= 8'd1 && total <= 8'd4) ? int'(total) : $urandom_range(1, 3);
        for (int n = 0; n < nsub; n++) begin
            num   = 8'(n);
            hcode = code;
            len   = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(100, 255))
                                                 : 8'($urandom_range(0, 10));
            nbytes = int'(len);
            pick  = $urandom_range(0, 31);
            fault = (pick < 6) ? fault_t'(pick + 1) : FLT_NONE;
            case (fault)
                FLT_CODE:    hcode = code ^ 8'($urandom_range(1, 255));
                FLT_SKIP:    num = num + 8'($urandom_range(1, 3));
                FLT_RESTART: num = 8'd0;
                FLT_SHORT:   if (len != 8'd0) nbytes = $urandom_range(0, len - 1);
                FLT_EXTRA:   nbytes = int'(len) + $urandom_range(1, 2);
                FLT_NOISE:   send_item(in_item_t'(IN_W'({$urandom, $urandom})));
                default: ;
            endcase
            send_item(mk_header(id, hcode, num, total, len));
            for (int b = 0; b < nbytes; b++)
                send_item(mk_byte(8'($urandom)));
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = n_items + count;
        while (n_items < stop_at) begin
            send_long_packet();
            if ($urandom_range(0, 15) == 0)
                wait_for_results();
        end
    endtask

    // One record walked through every subpacket number up to the top
    task automatic run_number_limit();
        logic [7:0] id;
        logic [7:0] len;
        id = 8'hC3;
        // Drop whatever record is open so the walk starts on a new id
        send_item(mk_header(8'hC4, 8'h00, 8'd1, 8'd0, 8'd0));
        for (int k = 0; k < 256; k++) begin
            len = (k % 64 == 0) ? 8'd2 : 8'd0;
            send_item(mk_header(id, cfg_scan, 8'(k), 8'd0, len));
            for (int b = 0; b < int'(len); b++)
                send_item(mk_byte(8'($urandom)));
        end
        // Number 255 again: no wrap, only 0 may follow; its byte is dropped
        send_item(mk_header(id, cfg_scan, 8'hFF, 8'd0, 8'd1));
        send_item(mk_byte(8'($urandom)));
        // Restart at 0 as the final subpacket of the record
        send_item(mk_header(id, cfg_scan, 8'd0, 8'd1, 8'd3));
        for (int b = 0; b < 3; b++)
            send_item(mk_byte(8'($urandom)));
    endtask

    initial begin
        // Directed rows under the reset register values
        add_row(mk_byte(8'hFF), 1'b1, mk_result(ST_NOT_HEADER, 1'b0, 16'd0));
        add_row(mk_header(8'hFF, 8'hFF, 8'd5, 8'd8, 8'd3), 1'b1,
                mk_result(ST_BAD_START, 1'b0, 16'd0));
        add_row(mk_byte(8'h00), 1'b1, mk_result(ST_NOT_HEADER, 1'b0, 16'd0));
        add_row(mk_header(8'h00, 8'h02, 8'd0, 8'd0, 8'd0), 1'b1,
                mk_result(ST_ACCEPTED, 1'b0, 16'd0));
        add_row(mk_header(8'h00, 8'h02, 8'd0, 8'd1, 8'd0), 1'b1,
                mk_result(ST_ACCEPTED, 1'b1, 16'd0));
        add_row(mk_header(8'h00, 8'h03, 8'd1, 8'd3, 8'd2), 1'b1,
                mk_result(ST_CODE_MISM, 1'b0, 16'd0));
        add_row(mk_header(8'h00, 8'h02, 8'd2, 8'd3, 8'd2), 1'b1,
                mk_result(ST_SEQ_GAP, 1'b0, 16'd0));
        add_row(mk_header(8'h00, 8'h02, 8'd1, 8'd3, 8'd2));
        add_row(mk_byte(8'hA5));
        // Next header abandons the byte still owed
        add_row(mk_header(8'h00, 8'h02, 8'd2, 8'd3, 8'd3));
        add_row(mk_byte(8'h5A));
        add_row(mk_byte(8'hFF));
        add_row(mk_byte(8'h00));
        add_row(mk_byte(8'h11));
        // Restart at number 0 keeps the byte count
        add_row(mk_header(8'h00, 8'h02, 8'd0, 8'd2, 8'd1));
        add_row(mk_byte(8'h80));
        add_row(mk_header(8'h00, 8'h02, 8'd1, 8'd2, 8'd0));
        add_row(mk_header(8'hFF, 8'hFF, 8'd0, 8'hFF, 8'hFF));
        add_row(mk_byte(8'hFF));
        add_row(in_item_t'({49{1'b1}}));
        add_row(mk_header(8'h00, 8'h00, 8'd0, 8'hFF, 8'd2));
        add_row(mk_header(8'h42, 8'h02, 8'd3, 8'd4, 8'd1), 1'b1,
                mk_result(ST_BAD_START, 1'b0, 16'd0));
        add_row(mk_byte(8'h33), 1'b1, mk_result(ST_NOT_HEADER, 1'b0, 16'd0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);
        wait_for_results();

        // Random traffic under several register settings
        stall_mode = STALL_RANDOM;
        gap_max    = 4;
        set_config(8'h00, 16'h0000);
        run_random(100);
        wait_for_results();

        stall_mode = STALL_RUNS;
        gap_max    = 8;
        set_config(8'hFF, 16'hFFFF);
        run_random(100);
        wait_for_results();

        stall_mode = STALL_NONE;
        gap_max    = 1;
        set_config(8'($urandom_range(0, 3)), 16'($urandom_range(0, 40)));
        run_random(100);
        wait_for_results();

        // Subpacket number walk at full rate with light stalls
        stall_mode = STALL_RANDOM;
        gap_max    = 0;
        set_config(8'h5C, 16'd4);
        run_number_limit();
        wait_for_results();
        repeat (5) @(posedge aclk);

        if (results_due.size() != 0)
            errors++;
        $display("Covered %0d transfers under %0d register settings; %0d results checked.",
                 n_items, n_settings + 1, n_checked);
        $display("Headers accepted %0d, rejected %0d; packets done %0d, scan ready %0d.",
                 n_accepted, n_rejected, n_done, n_scan);
        if (errors == 0) begin
            $display("** subpacket_reassembly_checker: PASSED **");
        end else begin
            $display("** subpacket_reassembly_checker: FAILED **");
        end
        $finish;
    end

endmodule
